[rtl/core/lpn_pkg.sv]
// shared types and constants for the normalised two-point line block
`default_nettype none
package lpn_pkg;

  localparam int COORD_W  = 16;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * COORD_W;
  localparam int SQ_W     = 34;               // a*a+b*b padded to an even width
  localparam int ROOT_W   = 48;               // floor(sqrt(S * 2^62))
  localparam int REM_W    = ROOT_W + 1;
  localparam int QUO_W    = 32;
  localparam int LANES    = 3;
  localparam int AB_SHIFT = 29;               // (30 + 31) - QUO_W
  localparam int C_SHIFT  = 15;               // (16 + 31) - QUO_W
  localparam int NORM_W   = 32;
  localparam int OFF_W    = 33;

  localparam logic [OFF_W-1:0]  OFF_ONE = OFF_W'(65536);
  localparam logic [QUO_W:0]    CAP_AB  = (QUO_W+1)'(32'h7FFF_FFFF);
  localparam logic [QUO_W:0]    CAP_C   = (QUO_W+1)'(32'hFFFF_FFFF);

  localparam int LANE_A = 0;
  localparam int LANE_B = 1;
  localparam int LANE_C = 2;

  typedef struct packed {
    logic ident;
    logic neg_a;
    logic neg_b;
    logic neg_c;
  } side_t;

  typedef struct packed {
    side_t               side;
    logic [DIFF_W-1:0]   am;
    logic [DIFF_W-1:0]   bm;
    logic [PROD_W-1:0]   cm;
  } pay_t;

endpackage
`default_nettype wire

[rtl/core/line_through_two_points_normalized.sv]
// Normalised line a*x+b*y+c=0 through two points: a and b as a unit normal in Q1.30,
// c as a signed origin distance with 16 fraction bits, identical points flagged
// invalid (a=0, b=0, c=1.0, line_valid low). One pair is taken every cycle unless the
// output stalls; each beat passes through three front stages, a chain of 48
// square root cells (one root bit each), a chain of 32 divider cells (one quotient
// bit of a, b and c each) and the output register. The whole pipe advances together
// and holds while a result waits on out_tready.
`default_nettype none
module line_through_two_points_normalized import lpn_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [63:0]   in_tdata,   // first_x, first_y, second_x, second_y
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [103:0]       out_tdata,  // normal_a, normal_b, offset_c, zero pad
  output logic               out_tuser   // line_valid
);

  localparam int SQ_CELLS  = ROOT_W;
  localparam int DIV_CELLS = QUO_W;

  logic en;
  logic acc;

  logic                 fr_vld;
  logic [SQ_W-1:0]      fr_sum;
  pay_t                 fr_pay;

  logic                 sq_vld  [SQ_CELLS+1];
  logic [REM_W-1:0]     sq_rem  [SQ_CELLS+1];
  logic [ROOT_W-1:0]    sq_root [SQ_CELLS+1];
  logic [SQ_W-1:0]      sq_rad  [SQ_CELLS+1];
  pay_t                 sq_pay  [SQ_CELLS+1];

  logic                         dv_vld  [DIV_CELLS+1];
  logic [LANES-1:0][ROOT_W-1:0] dv_rem  [DIV_CELLS+1];
  logic [LANES-1:0][QUO_W-1:0]  dv_q    [DIV_CELLS+1];
  logic [ROOT_W-1:0]            dv_d    [DIV_CELLS+1];
  side_t                        dv_side [DIV_CELLS+1];

  logic [LANES-1:0][QUO_W:0]    rsum;
  logic [QUO_W-1:0]             mag_a, mag_b, mag_c;
  side_t                        fin_side;
  logic [NORM_W-1:0]            na_nxt, nb_nxt;
  logic [OFF_W-1:0]             oc_nxt;

  logic                 out_vld_r;
  logic [NORM_W-1:0]    na_r, nb_r;
  logic [OFF_W-1:0]     oc_r;
  logic                 lv_r;

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;
  assign acc       = in_tvalid && en;

  lpn_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (acc),
    .x1_i  (in_tdata[15:0]),
    .y1_i  (in_tdata[31:16]),
    .x2_i  (in_tdata[47:32]),
    .y2_i  (in_tdata[63:48]),
    .vld_o (fr_vld),
    .sum_o (fr_sum),
    .pay_o (fr_pay)
  );

  assign sq_vld[0]  = fr_vld;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = fr_sum;
  assign sq_pay[0]  = fr_pay;

  for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sq
    lpn_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (sq_vld[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .rad_i  (sq_rad[k]),
      .pay_i  (sq_pay[k]),
      .vld_o  (sq_vld[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .rad_o  (sq_rad[k+1]),
      .pay_o  (sq_pay[k+1])
    );
  end

  // dividends start pre-shifted; every remaining dividend bit is zero
  assign dv_rem[0][LANE_A] = ROOT_W'({sq_pay[SQ_CELLS].am, AB_SHIFT'(0)});
  assign dv_rem[0][LANE_B] = ROOT_W'({sq_pay[SQ_CELLS].bm, AB_SHIFT'(0)});
  assign dv_rem[0][LANE_C] = ROOT_W'({sq_pay[SQ_CELLS].cm, C_SHIFT'(0)});
  assign dv_vld[0]  = sq_vld[SQ_CELLS];
  assign dv_q[0]    = '0;
  assign dv_d[0]    = sq_root[SQ_CELLS];
  assign dv_side[0] = sq_pay[SQ_CELLS].side;

  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
    lpn_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (dv_vld[k]),
      .rem_i  (dv_rem[k]),
      .q_i    (dv_q[k]),
      .d_i    (dv_d[k]),
      .side_i (dv_side[k]),
      .vld_o  (dv_vld[k+1]),
      .rem_o  (dv_rem[k+1]),
      .q_o    (dv_q[k+1]),
      .d_o    (dv_d[k+1]),
      .side_o (dv_side[k+1])
    );
  end

  // round half away from zero on the magnitude, then saturate and sign; identical points get the invalid marker
  always_comb begin
    fin_side = dv_side[DIV_CELLS];
    for (int l = 0; l < LANES; l++) begin
      rsum[l] = {1'b0, dv_q[DIV_CELLS][l]}
              + (QUO_W+1)'({dv_rem[DIV_CELLS][l], 1'b0} >= {1'b0, dv_d[DIV_CELLS]});
    end
    mag_a  = (rsum[LANE_A] > CAP_AB) ? QUO_W'(CAP_AB) : QUO_W'(rsum[LANE_A]);
    mag_b  = (rsum[LANE_B] > CAP_AB) ? QUO_W'(CAP_AB) : QUO_W'(rsum[LANE_B]);
    mag_c  = (rsum[LANE_C] > CAP_C)  ? QUO_W'(CAP_C)  : QUO_W'(rsum[LANE_C]);
    na_nxt = fin_side.neg_a ? NORM_W'(-mag_a) : NORM_W'(mag_a);
    nb_nxt = fin_side.neg_b ? NORM_W'(-mag_b) : NORM_W'(mag_b);
    oc_nxt = fin_side.neg_c ? OFF_W'(-{1'b0, mag_c}) : OFF_W'({1'b0, mag_c});
    if (fin_side.ident) begin
      na_nxt = '0;
      nb_nxt = '0;
      oc_nxt = OFF_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld[DIV_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na_r <= na_nxt;
      nb_r <= nb_nxt;
      oc_r <= oc_nxt;
      lv_r <= !fin_side.ident;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'b0, oc_r, nb_r, na_r};
  assign out_tuser  = lv_r;

endmodule
`default_nettype wire

[rtl/core/lpn_sqrt_cell.sv]
// one cell of the square root chain: settles one root bit per beat
`default_nettype none
module lpn_sqrt_cell import lpn_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              vld_i,
  input  wire logic [REM_W-1:0]  rem_i,
  input  wire logic [ROOT_W-1:0] root_i,
  input  wire logic [SQ_W-1:0]   rad_i,
  input  wire pay_t              pay_i,
  output logic                   vld_o,
  output logic [REM_W-1:0]       rem_o,
  output logic [ROOT_W-1:0]      root_o,
  output logic [SQ_W-1:0]        rad_o,
  output pay_t                   pay_o
);

  logic [REM_W+1:0]  rem2;
  logic [REM_W+1:0]  trial;
  logic              ge;
  logic [REM_W-1:0]  rem_nxt;
  logic [ROOT_W-1:0] root_nxt;
  logic [SQ_W-1:0]   rad_nxt;
  logic              vld_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [SQ_W-1:0]   rad_r;
  pay_t              pay_r;

  always_comb begin
    rem2     = {rem_i, rad_i[SQ_W-1 -: 2]};
    trial    = {1'b0, root_i, 2'b01};
    ge       = (rem2 >= trial);
    rem_nxt  = ge ? REM_W'(rem2 - trial) : REM_W'(rem2);
    root_nxt = {root_i[ROOT_W-2:0], ge};
    rad_nxt  = {rad_i[SQ_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      rad_r  <= rad_nxt;
      pay_r  <= pay_i;
    end
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign rad_o  = rad_r;
  assign pay_o  = pay_r;

endmodule
`default_nettype wire

[rtl/core/lpn_div_cell.sv]
// one cell of the divider chain: one quotient bit per beat for a, b and c
`default_nettype none
module lpn_div_cell import lpn_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        vld_i,
  input  wire logic [LANES-1:0][ROOT_W-1:0] rem_i,
  input  wire logic [LANES-1:0][QUO_W-1:0]  q_i,
  input  wire logic [ROOT_W-1:0]            d_i,
  input  wire side_t                        side_i,
  output logic                              vld_o,
  output logic [LANES-1:0][ROOT_W-1:0]      rem_o,
  output logic [LANES-1:0][QUO_W-1:0]       q_o,
  output logic [ROOT_W-1:0]                 d_o,
  output side_t                             side_o
);

  logic [LANES-1:0][ROOT_W-1:0] rem_nxt;
  logic [LANES-1:0][QUO_W-1:0]  q_nxt;
  logic [ROOT_W:0]              rem2;
  logic                         ge;
  logic                         vld_r;
  logic [LANES-1:0][ROOT_W-1:0] rem_r;
  logic [LANES-1:0][QUO_W-1:0]  q_r;
  logic [ROOT_W-1:0]            d_r;
  side_t                        side_r;

  always_comb begin
    rem_nxt = '0;
    q_nxt   = '0;
    rem2    = '0;
    ge      = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      rem2       = {rem_i[l], 1'b0};
      ge         = (rem2 >= {1'b0, d_i});
      rem_nxt[l] = ge ? ROOT_W'(rem2 - {1'b0, d_i}) : ROOT_W'(rem2);
      q_nxt[l]   = {q_i[l][QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      d_r    <= d_i;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign q_o    = q_r;
  assign d_o    = d_r;
  assign side_o = side_r;

endmodule
`default_nettype wire

[rtl/core/lpn_front.sv]
// front end: differences, cross products, magnitudes and sum of squares
`default_nettype none
module lpn_front import lpn_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                vld_i,
  input  wire logic [COORD_W-1:0]  x1_i,
  input  wire logic [COORD_W-1:0]  y1_i,
  input  wire logic [COORD_W-1:0]  x2_i,
  input  wire logic [COORD_W-1:0]  y2_i,
  output logic                     vld_o,
  output logic [SQ_W-1:0]          sum_o,
  output pay_t                     pay_o
);

  // stage 1
  logic                       s1_vld_r;
  logic signed [DIFF_W-1:0]   a_r, b_r;
  logic signed [PROD_W-1:0]   p1_r, p2_r;
  // stage 2
  logic                       s2_vld_r;
  logic [PROD_W-1:0]          sqa_r, sqb_r;
  pay_t                       s2_pay_r;
  // stage 3
  logic                       s3_vld_r;
  logic [SQ_W-1:0]            sum_r;
  pay_t                       s3_pay_r;

  logic signed [PROD_W:0]     diff;
  logic [DIFF_W-1:0]          am, bm;
  logic [2*DIFF_W-1:0]        sqa_full, sqb_full;
  pay_t                       pay_nxt;

  always_comb begin
    diff              = {p1_r[PROD_W-1], p1_r} - {p2_r[PROD_W-1], p2_r};
    am                = a_r[DIFF_W-1] ? DIFF_W'(-a_r) : DIFF_W'(a_r);
    bm                = b_r[DIFF_W-1] ? DIFF_W'(-b_r) : DIFF_W'(b_r);
    sqa_full          = am * am;
    sqb_full          = bm * bm;
    pay_nxt.side.ident = (a_r == '0) && (b_r == '0);
    pay_nxt.side.neg_a = a_r[DIFF_W-1];
    pay_nxt.side.neg_b = b_r[DIFF_W-1];
    pay_nxt.side.neg_c = diff[PROD_W];
    pay_nxt.am         = am;
    pay_nxt.bm         = bm;
    pay_nxt.cm         = diff[PROD_W] ? PROD_W'(-diff) : PROD_W'(diff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= vld_i;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r      <= $signed({y1_i[COORD_W-1], y1_i}) - $signed({y2_i[COORD_W-1], y2_i});
      b_r      <= $signed({x2_i[COORD_W-1], x2_i}) - $signed({x1_i[COORD_W-1], x1_i});
      p1_r     <= $signed(x1_i) * $signed(y2_i);
      p2_r     <= $signed(x2_i) * $signed(y1_i);
      sqa_r    <= PROD_W'(sqa_full);
      sqb_r    <= PROD_W'(sqb_full);
      s2_pay_r <= pay_nxt;
      sum_r    <= SQ_W'(sqa_r) + SQ_W'(sqb_r);
      s3_pay_r <= s2_pay_r;
    end
  end

  assign vld_o = s3_vld_r;
  assign sum_o = sum_r;
  assign pay_o = s3_pay_r;

endmodule
`default_nettype wire

[rtl/core/lpn_checker.sv]
// port-level checks for the normalised line block, bound to the top level
`default_nettype none
module lpn_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [103:0] out_tdata,
  input wire logic         out_tuser
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // input side only waits while a result is stuck at the output
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  // invalid line carries the marker coefficients
  a_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      out_tdata[31:0] == 32'd0 && out_tdata[63:32] == 32'd0
      && out_tdata[96:64] == 33'd65536)
    else $error("invalid line with wrong coefficients");

  // unit normal components stay within +-1.0
  a_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      $signed(out_tdata[31:0]) <= 32'sd1073741824
      && $signed(out_tdata[31:0]) >= -32'sd1073741824
      && $signed(out_tdata[63:32]) <= 32'sd1073741824
      && $signed(out_tdata[63:32]) >= -32'sd1073741824)
    else $error("normal component beyond one");

endmodule

bind line_through_two_points_normalized lpn_checker u_lpn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

[tb/testbench.sv]
// testbench for the normalised two-point line block
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import lpn_pkg::*;

  typedef struct {
    logic [31:0] na;
    logic [31:0] nb;
    logic [32:0] oc;
    logic        ok;
  } line_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [63:0]   in_tdata = '0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [103:0]  out_tdata;
  logic          out_tuser;

  line_t  line_q[$];
  int     n_sent, n_got, n_bad, n_invalid, cycles;
  int     gap_pct = 36;
  bit     stall_on = 1'b1;
  bit     hold_rx = 1'b0;
  int     hold_len = 0;

  line_through_two_points_normalized i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // integer square root of a 128-bit value, 64-bit result
  function automatic logic [63:0] isqrt128(logic [127:0] v);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if ({64'd0, c} * {64'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  // magnitude divided by root, rounded half away, saturated
  function automatic logic [63:0] div_rnd(logic [127:0] num, logic [63:0] d,
                                          logic [63:0] cap);
    logic [127:0] q;
    logic [127:0] rem;
    q = num / {64'd0, d};
    rem = num - q * {64'd0, d};
    if (rem >= {64'd0, d} - rem) q = q + 1;
    if (q > {64'd0, cap}) return cap;
    return q[63:0];
  endfunction

  function automatic line_t predict_line(logic [63:0] d);
    longint x1, y1, x2, y2, a, b, c;
    logic [127:0] s;
    logic [63:0] r, am, bm, cm;
    line_t l;
    x1 = longint'($signed(d[15:0]));
    y1 = longint'($signed(d[31:16]));
    x2 = longint'($signed(d[47:32]));
    y2 = longint'($signed(d[63:48]));
    a = y1 - y2;
    b = x2 - x1;
    if (a == 0 && b == 0) begin
      l.na = '0; l.nb = '0; l.oc = OFF_ONE; l.ok = 1'b0;
      return l;
    end
    c = x1 * y2 - x2 * y1;
    am = a < 0 ? -a : a;
    bm = b < 0 ? -b : b;
    cm = c < 0 ? -c : c;
    s = {64'd0, am} * {64'd0, am} + {64'd0, bm} * {64'd0, bm};
    r = isqrt128(s << 62);
    am = div_rnd({64'd0, am} << 61, r, 64'h7FFF_FFFF);
    bm = div_rnd({64'd0, bm} << 61, r, 64'h7FFF_FFFF);
    cm = div_rnd({64'd0, cm} << 47, r, 64'hFFFF_FFFF);
    l.na = a < 0 ? -am[31:0] : am[31:0];
    l.nb = b < 0 ? -bm[31:0] : bm[31:0];
    l.oc = c < 0 ? -{1'b0, cm[31:0]} : {1'b0, cm[31:0]};
    l.ok = 1'b1;
    return l;
  endfunction

  // valid stays up between back-to-back beats and drops only while idling
  task automatic send_pair(logic [15:0] x1, logic [15:0] y1,
                           logic [15:0] x2, logic [15:0] y2);
    while (stall_on && $urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y2, x2, y1, x1};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    line_q.push_back(predict_line({y2, x2, y1, x1}));
    n_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (line_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] rnd_coord();
    case ($urandom_range(4))
      0: return 16'(32'($urandom_range(16)) - 8);
      1: return $urandom_range(1) ? 16'h7FFF - 16'($urandom_range(3))
                                   : 16'h8000 + 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_extremes();
    logic [15:0] v[6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h8001};
    for (int i = 0; i < 6; i++)
      send_pair(v[i], v[(i + 1) % 6], v[(i + 3) % 6], v[(i + 4) % 6]);
    send_pair(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
    send_pair(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    send_pair(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_pair(16'd0, 16'd0, 16'd5, 16'd0);
    send_pair(16'd0, 16'd0, 16'd0, 16'h8000);
    send_pair(16'd1, 16'd1, 16'd3, 16'd3);
    send_pair(16'd0, 16'd0, 16'd1, 16'd2);
    send_pair(16'd1, 16'd0, 16'd0, 16'd1);
  endtask

  task automatic test_identical_points();
    logic [15:0] x, y;
    send_pair(16'd0, 16'd0, 16'd0, 16'd0);
    send_pair(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    for (int i = 0; i < 5; i++) begin
      x = 16'($urandom); y = 16'($urandom);
      send_pair(x, y, x, y);
    end
  endtask

  task automatic test_random(int n);
    logic [15:0] x, y;
    for (int i = 0; i < n; i++) begin
      x = rnd_coord(); y = rnd_coord();
      if ($urandom_range(49) == 0) send_pair(x, y, x, y);
      else if ($urandom_range(9) == 0)
        send_pair(x, y, x + 16'($urandom_range(2)), y - 16'($urandom_range(2)));
      else send_pair(x, y, rnd_coord(), rnd_coord());
    end
  endtask

  task automatic test_no_gaps();
    stall_on = 1'b0;
    test_random(300);
    wait_drained();
    stall_on = 1'b1;
  endtask

  // receiver holds off long enough for the pipe to fill and stall the input
  task automatic test_backpressure();
    hold_len = 300;
    hold_rx  = 1'b1;
    test_random(150);
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (hold_rx) begin
      out_tready <= 1'b0;
      hold_len--;
      if (hold_len <= 0) hold_rx <= 1'b0;
    end else begin
      out_tready <= !stall_on || $urandom_range(99) >= gap_pct;
    end
  end

  always @(posedge clk) begin
    line_t e;
    if (rst_n && out_tvalid && out_tready) begin
      n_got++;
      if (line_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected beat: %h", out_tdata);
      end else begin
        e = line_q.pop_front();
        if (!e.ok) n_invalid++;
        if (out_tdata[31:0] !== e.na || out_tdata[63:32] !== e.nb ||
            out_tdata[96:64] !== e.oc || out_tuser !== e.ok) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch beat %0d: exp a=%h b=%h c=%h v=%b got a=%h b=%h c=%h v=%b",
                     n_got, e.na, e.nb, e.oc, e.ok, out_tdata[31:0],
                     out_tdata[63:32], out_tdata[96:64], out_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("timed out with %0d beats outstanding", line_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_identical_points();
    test_random(500);
    test_no_gaps();
    test_backpressure();
    wait_drained();
    test_random(580);
    wait_drained();
    repeat (200) @(posedge clk);
    $display("sent %0d point pairs, checked %0d lines (%0d invalid), %0d errors",
             n_sent, n_got, n_invalid, n_bad);
    if (n_bad == 0 && line_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire
